// ===== rtl/core/xcs_pkg.sv =====
// ----------------------------------------------------------------------------
// xcs_pkg
// Shared types, constants and helpers for the XTEA counter-mode stream core.
// ----------------------------------------------------------------------------
package xcs_pkg;

  localparam logic [31:0] XCS_DELTA     = 32'h9E3779B9;
  localparam int unsigned XCS_SHL       = 4;
  localparam int unsigned XCS_SHR       = 5;
  localparam int unsigned XCS_KSEL_SHR  = 11;

  // Configuration register indexes
  localparam logic [1:0] XCS_REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] XCS_REG_KEY_HIGH = 2'd1;

  // Payload that walks the cell chain alongside its valid bit
  typedef struct packed {
    logic [31:0] v0;
    logic [31:0] v1;
    logic [63:0] data;
    logic [3:0]  nbytes;
  } xcs_word_t;

  // Keep byte i when the count exceeds i; counts above eight keep all bytes
  function automatic logic [63:0] xcs_byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (n > 4'(i)) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/xcs_round_cell.sv =====
// ----------------------------------------------------------------------------
// xcs_round_cell
// One XTEA half round with a register stage; updates v0 or v1.
// ----------------------------------------------------------------------------
module xcs_round_cell
  import xcs_pkg::*;
#(
  parameter logic [31:0] SUM  = 32'h0,
  parameter bit          HALF = 1'b0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [127:0]     key,
  input  logic             in_vld,
  input  xcs_word_t        in_word,
  output logic             out_vld_r,
  output xcs_word_t        out_word_r
);

  // Key word is fixed per cell by its round constant
  localparam logic [1:0] KIDX = HALF ? SUM[XCS_KSEL_SHR +: 2] : SUM[1:0];

  logic [31:0] src;
  logic [31:0] mix;
  logic [31:0] kterm;
  xcs_word_t   word_nxt;

  always_comb begin
    src   = HALF ? in_word.v0 : in_word.v1;
    mix   = ((src << XCS_SHL) ^ (src >> XCS_SHR)) + src;
    kterm = SUM + key[32*KIDX +: 32];
    word_nxt = in_word;
    if (HALF) begin
      word_nxt.v1 = in_word.v1 + (mix ^ kterm);
    end else begin
      word_nxt.v0 = in_word.v0 + (mix ^ kterm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= word_nxt;
    end
  end

endmodule

// ===== rtl/core/xcs_out_skid.sv =====
// ----------------------------------------------------------------------------
// xcs_out_skid
// Keystream XOR, byte masking, output register and one-word skid buffer.
// ----------------------------------------------------------------------------
module xcs_out_skid
  import xcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pipe_vld,
  input  xcs_word_t   pipe_word,
  output logic        hold_r,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_block
);

  logic        out_vld_r;
  logic [63:0] out_data_r;
  logic [63:0] skid_data_r;
  logic [63:0] res;
  logic        take;

  assign res  = (pipe_word.data ^ {pipe_word.v1, pipe_word.v0})
                & xcs_byte_mask(pipe_word.nbytes);
  assign take = out_vld_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      hold_r    <= 1'b0;
    end else if (hold_r) begin
      // chain is frozen; drain the skid word once the output is taken
      if (take) begin
        hold_r <= 1'b0;
      end
    end else if (pipe_vld) begin
      if (!out_vld_r || take) begin
        out_vld_r <= 1'b1;
      end else begin
        hold_r <= 1'b1;
      end
    end else if (take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (pipe_vld) begin
      if (!out_vld_r || take) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_result_block = out_data_r;

endmodule

// ===== rtl/core/xtea_ctr_stream_crypt.sv =====
// ----------------------------------------------------------------------------
// xtea_ctr_stream_crypt
// XTEA counter-mode stream cipher, one 64-bit data word per cycle unless a stall holds it.
// ----------------------------------------------------------------------------
//  channel | ports                                   | word
//  in      | in_valid / in_stall                     | nonce, data, start, count
//  out     | out_valid / out_stall                   | result block
//  cfg     | cfg_we, cfg_index, cfg_wdata            | key_low, key_high
//
//  A chain of 2*ROUNDS half-round cells takes one word per cycle unless held;
//  each word passes through the cells and then the output register.
//  The block counter is updated as each word enters the chain.
//  A stalled output parks one word in a skid register; the chain and
//  in_stall then hold until it drains. Reset clears valids, keys and counter.
// ----------------------------------------------------------------------------
module xtea_ctr_stream_crypt
  import xcs_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_nonce,
  input  logic [63:0] in_data_block,
  input  logic        in_start_of_message,
  input  logic [3:0]  in_valid_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_block,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int NCELL = 2 * ROUNDS;

  logic [63:0]  key_low_r;
  logic [63:0]  key_high_r;
  logic [31:0]  block_counter_r;
  logic [31:0]  block_counter_nxt;
  logic [31:0]  ctr_base;
  logic         hold_r;
  logic         adv;

  logic         vld   [NCELL+1];
  xcs_word_t    word  [NCELL+1];

  assign adv      = !hold_r;
  assign in_stall = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        XCS_REG_KEY_LOW:  key_low_r  <= cfg_wdata;
        XCS_REG_KEY_HIGH: key_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Zero-length words leave the counter where start put it
  always_comb begin
    ctr_base = in_start_of_message ? 32'd0 : block_counter_r;
    block_counter_nxt = (in_valid_bytes == 4'd0) ? ctr_base : ctr_base + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_counter_r <= '0;
    end else if (in_valid && !in_stall) begin
      block_counter_r <= block_counter_nxt;
    end
  end

  always_comb begin
    vld[0]         = in_valid;
    word[0].v0     = in_nonce;
    word[0].v1     = ctr_base;
    word[0].data   = in_data_block;
    word[0].nbytes = in_valid_bytes;
  end

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    localparam logic [31:0] CSUM =
      32'(64'(c / 2 + c % 2) * 64'(XCS_DELTA));
    xcs_round_cell #(
      .SUM  (CSUM),
      .HALF (c % 2 == 1)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (adv),
      .key        ({key_high_r, key_low_r}),
      .in_vld     (vld[c]),
      .in_word    (word[c]),
      .out_vld_r  (vld[c+1]),
      .out_word_r (word[c+1])
    );
  end

  xcs_out_skid u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .pipe_vld         (vld[NCELL]),
    .pipe_word        (word[NCELL]),
    .hold_r           (hold_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block)
  );

endmodule

// ===== test/xtea_ctr_stream_crypt_test.sv =====
// ----------------------------------------------------------------------------
// xtea_ctr_stream_crypt_test
// Self-checking bench for the XTEA counter-mode stream core. A short table
// of corner-case words runs first. Random messages follow under several key
// settings. Input gaps and output stalls come at random. Every result word is
// checked against a local XTEA/CTR predictor that keeps its own key and
// block counter.
// ----------------------------------------------------------------------------
module xtea_ctr_stream_crypt_test
  import xcs_pkg::*;
;

  localparam int ROUNDS     = 32;
  localparam int LATENCY    = 2 * ROUNDS + 1;
  localparam int STALL_MAX  = 1000;
  localparam int DIR_N      = 22;
  localparam int DIR_SPLIT  = 12;
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 125;

  // Indexes the block has no register for
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] nonce;
    logic [63:0] data;
    logic        sop;
    logic [3:0]  nbytes;
    logic        fixed;
    logic [63:0] want;
  } row_t;

  logic        clk;
  logic        rst_n               = 1'b0;
  logic        in_valid            = 1'b0;
  logic        in_stall;
  logic [31:0] in_nonce            = '0;
  logic [63:0] in_data_block       = '0;
  logic        in_start_of_message = 1'b0;
  logic [3:0]  in_valid_bytes      = 4'd1;
  logic        out_valid;
  logic        out_stall           = 1'b0;
  logic [63:0] out_result_block;
  logic        cfg_we              = 1'b0;
  logic [1:0]  cfg_index           = '0;
  logic [63:0] cfg_wdata           = '0;

  // Typed-in expectation for the word currently on the input
  logic        row_fixed = 1'b0;
  logic [63:0] row_want  = '0;

  // Predictor state
  logic [63:0] key_lo    = '0;
  logic [63:0] key_hi    = '0;
  logic [31:0] blk_count = '0;

  logic [63:0] pending_blocks [$];
  int          errors      = 0;
  int          checked     = 0;
  int          sent        = 0;
  int          idle_cycles = 0;
  int          key_sets    = 1;
  int          stall_left  = 0;
  bit          idle_on     = 1'b1;

  // Columns: nonce, data, start, count, typed, expected
  row_t dir_rows [DIR_N] = '{
    '{32'h0000_0000, 64'h0, 1'b1, 4'd8, 1'b0, 64'h0},
    '{32'h0000_0000, ONES,  1'b0, 4'd0, 1'b1, 64'h0},
    '{32'hFFFF_FFFF, ONES,  1'b0, 4'd8, 1'b0, 64'h0},
    '{32'h1234_5678, 64'h0123_4567_89AB_CDEF, 1'b0, 4'd1, 1'b0, 64'h0},
    '{32'h1234_5678, ONES,  1'b0, 4'd7, 1'b0, 64'h0},
    '{32'h1234_5678, ONES,  1'b0, 4'd15, 1'b0, 64'h0},
    '{32'h1234_5678, 64'h0, 1'b0, 4'd9, 1'b0, 64'h0},
    '{32'hFFFF_FFFF, ONES,  1'b1, 4'd0, 1'b1, 64'h0},
    '{32'hFFFF_FFFF, 64'h0, 1'b0, 4'd4, 1'b0, 64'h0},
    '{32'h8000_0001, ONES,  1'b0, 4'd2, 1'b0, 64'h0},
    '{32'h8000_0001, 64'h0, 1'b0, 4'd3, 1'b0, 64'h0},
    '{32'h8000_0001, ONES,  1'b0, 4'd5, 1'b0, 64'h0},
    // all-ones key from here
    '{32'h0000_0000, 64'h0, 1'b1, 4'd8, 1'b0, 64'h0},
    '{32'hFFFF_FFFF, ONES,  1'b0, 4'd6, 1'b0, 64'h0},
    '{32'hFFFF_FFFF, ONES,  1'b0, 4'd10, 1'b0, 64'h0},
    '{32'hFFFF_FFFF, 64'h0, 1'b0, 4'd11, 1'b0, 64'h0},
    '{32'h5A5A_A5A5, 64'hA5A5_5A5A_F0F0_0F0F, 1'b0, 4'd12, 1'b0, 64'h0},
    '{32'h5A5A_A5A5, ONES,  1'b0, 4'd13, 1'b0, 64'h0},
    '{32'h5A5A_A5A5, ONES,  1'b0, 4'd0, 1'b1, 64'h0},
    '{32'h5A5A_A5A5, 64'h0, 1'b1, 4'd14, 1'b0, 64'h0},
    '{32'hFFFF_FFFF, ONES,  1'b1, 4'd8, 1'b0, 64'h0},
    '{32'hFFFF_FFFF, ONES,  1'b0, 4'd8, 1'b0, 64'h0}
  };

  xtea_ctr_stream_crypt #(
    .ROUNDS (ROUNDS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_nonce            (in_nonce),
    .in_data_block       (in_data_block),
    .in_start_of_message (in_start_of_message),
    .in_valid_bytes      (in_valid_bytes),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_block    (out_result_block),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] xtea_keystream(input logic [31:0] nonce,
                                                 input logic [31:0] ctr);
    logic [31:0] k [4];
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] sum;
    k[0] = key_lo[31:0];
    k[1] = key_lo[63:32];
    k[2] = key_hi[31:0];
    k[3] = key_hi[63:32];
    a    = nonce;
    b    = ctr;
    sum  = '0;
    for (int r = 0; r < ROUNDS; r++) begin
      a   = a + ((((b << XCS_SHL) ^ (b >> XCS_SHR)) + b) ^ (sum + k[sum[1:0]]));
      sum = sum + XCS_DELTA;
      b   = b + ((((a << XCS_SHL) ^ (a >> XCS_SHR)) + a) ^ (sum + k[sum[12:11]]));
    end
    return {b, a};
  endfunction

  function automatic logic [63:0] keep_bytes(input logic [3:0] n);
    if (n >= 4'd8) begin
      return ONES;
    end
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // Result of one word; advances the block counter when a block is consumed
  function automatic logic [63:0] crypt_word(input logic [31:0] nonce,
                                             input logic [63:0] data,
                                             input logic sop,
                                             input logic [3:0] nbytes);
    logic [63:0] res;
    if (sop) begin
      blk_count = '0;
    end
    if (nbytes == 4'd0) begin
      return 64'h0;
    end
    res       = (data ^ xtea_keystream(nonce, blk_count)) & keep_bytes(nbytes);
    blk_count = blk_count + 32'd1;
    return res;
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    logic [63:0] want;
    bit          busy;
    if (rst_n) begin
      busy = 1'b0;
      if (cfg_we) begin
        busy = 1'b1;
        case (cfg_index)
          XCS_REG_KEY_LOW:  key_lo = cfg_wdata;
          XCS_REG_KEY_HIGH: key_hi = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_stall === 1'b0) begin
        busy = 1'b1;
        want = crypt_word(in_nonce, in_data_block, in_start_of_message, in_valid_bytes);
        if (row_fixed) begin
          want = row_want;
        end
        pending_blocks.push_back(want);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        busy = 1'b1;
        checked++;
        if (pending_blocks.size() == 0) begin
          errors++;
          $display("%0t: result_block with nothing pending, expected none, got %h",
                   $time, out_result_block);
        end else begin
          want = pending_blocks.pop_front();
          if (out_result_block !== want) begin
            errors++;
            $display("%0t: result_block mismatch, expected %h, got %h",
                     $time, want, out_result_block);
          end
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    wait (rst_n);
    while (idle_cycles < STALL_MAX) @(posedge clk);
    $display("%0t: no word moved for %0d cycles, %0d results still pending",
             $time, STALL_MAX, pending_blocks.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_block(input logic [31:0] nonce, input logic [63:0] data,
                            input logic sop, input logic [3:0] nbytes,
                            input logic fixed, input logic [63:0] want);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid            <= 1'b1;
    in_nonce            <= nonce;
    in_data_block       <= data;
    in_start_of_message <= sop;
    in_valid_bytes      <= nbytes;
    row_fixed           <= fixed;
    row_want            <= want;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sent++;
  endtask

  // Hold the input until every pending result is out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic key_write(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int          msg_left;
    logic [31:0] msg_nonce;
    logic        sop;
    logic [3:0]  nbytes;

    msg_left  = 0;
    msg_nonce = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corner words: reset key first, then the all-ones key
    for (int i = 0; i < DIR_N; i++) begin
      if (i == DIR_SPLIT) begin
        drain_results();
        key_write(XCS_REG_KEY_LOW, ONES);
        key_write(XCS_REG_KEY_HIGH, ONES);
        key_write(REG_SPARE_A, rand64());
        key_write(REG_SPARE_B, rand64());
        key_sets++;
      end
      send_block(dir_rows[i].nonce, dir_rows[i].data, dir_rows[i].sop,
                 dir_rows[i].nbytes, dir_rows[i].fixed, dir_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          key_write(XCS_REG_KEY_LOW, rand64());
          key_write(XCS_REG_KEY_HIGH, rand64());
        end
        1: begin
          key_write(XCS_REG_KEY_LOW, 64'h0);
          key_write(XCS_REG_KEY_HIGH, 64'h0);
        end
        2: begin
          key_write(XCS_REG_KEY_LOW, ONES);
          key_write(XCS_REG_KEY_HIGH, rand64());
        end
        3: begin
          key_write(XCS_REG_KEY_HIGH, rand64());
          key_write(REG_SPARE_B, rand64());
          key_write(XCS_REG_KEY_LOW, rand64());
          key_write(REG_SPARE_A, rand64());
        end
        default: begin
          key_write(XCS_REG_KEY_LOW, rand64());
          key_write(XCS_REG_KEY_HIGH, rand64());
        end
      endcase
      key_sets++;
      // No random input gaps or output stalls in phase 1 or in the last phase
      idle_on = (ph != 1) && (ph != PHASES - 1);

      for (int n = 0; n < PHASE_LEN; n++) begin
        if (ph == 2 && n == PHASE_LEN / 2) begin
          drain_results();
        end
        if (msg_left == 0) begin
          msg_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
          msg_nonce = $urandom;
          sop       = 1'b1;
        end else begin
          sop = 1'b0;
        end
        nbytes = (msg_left == 1) ? 4'($urandom_range(1, 8)) : 4'd8;
        // Noise: odd counts and stray restarts
        if ($urandom_range(0, 9) == 0) begin
          nbytes = 4'($urandom_range(0, 15));
          sop    = 1'($urandom);
        end
        msg_left--;
        send_block(msg_nonce, rand64(), sop, nbytes, 1'b0, 64'h0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Covered %0d words (%0d table rows) under %0d key settings with random stalls.",
             sent, DIR_N, key_sets);
    $display("Checked %0d result words, %0d mismatches.", checked, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
